// ===== sv/case_folding_byte_pattern_search_top_macros.svh =====
// assertion macros for the case folding byte pattern search block
`ifndef CASE_FOLDING_BYTE_PATTERN_SEARCH_TOP_MACROS_SVH
`define CASE_FOLDING_BYTE_PATTERN_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define CFBPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfbps assertion failed");
// checked on every edge, reset included
`define CFBPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cfbps assertion failed");
`else
`define CFBPS_ASSERT(lbl, clk, rst_n, prop)
`define CFBPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/cfbps_pkg.sv =====
// package: types, constants and helpers of the byte pattern search
`timescale 1ns / 1ps
package cfbps_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 64;
  // wide enough for a pattern length up to 256
  localparam int unsigned LEN_EXT_W = 9;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_DIFF = 8'h20;

  typedef enum logic [1:0] {
    CFG_PATTERN_LENGTH = 2'd0,
    CFG_IGNORE_CASE    = 2'd1,
    CFG_START_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] pattern_slot;
    logic [7:0] value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       load;
    logic       shift;
    logic       clr;
    logic       ignore_case;
    logic [5:0] slot;
    logic [7:0] value;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      r = c + ASCII_CASE_DIFF;
    end
    return r;
  endfunction

endpackage

// ===== sv/case_folding_byte_pattern_search_top.sv =====
// Byte pattern search with optional ASCII case folding.
// Input channel (in_valid_i / in_ready_o / in_data_i): each request either loads
// one pattern byte (op load, pattern_slot, value) or presents one stream byte
// (op data, value, last_byte). Output channel (out_valid_o / out_ready_i /
// out_data_o) gives one result per stream: found with the start position at
// the byte that completes the first match, or found clear at the last byte.
// The user must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while idle; the block itself does not enforce this. Throughput: one
// request per cycle while in_ready_o is high; the chain of per-position cells
// updates all prefix bits in the cycle the byte is taken, so nothing
// recirculates. A two-entry result queue parts the channels: requests keep
// flowing while a result waits; in_ready_o drops only when both entries are
// held because the receiver stalls.
// Reset clears the prefix bits, byte index, match flag, result queue and the
// registers (pattern length 1, case folding off, start offset 0). Pattern
// bytes are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`include "case_folding_byte_pattern_search_top_macros.svh"
module case_folding_byte_pattern_search_top #(
  parameter int unsigned MAX_PATTERN = cfbps_pkg::MAX_PATTERN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cfbps_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfbps_pkg::out_item_t out_data_o
);
  import cfbps_pkg::*;

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [6:0]  len_q;
  logic        icase_q;
  logic [31:0] offset_q;
  logic [31:0] idx_q, idx_d;
  logic        rep_q, rep_d;

  logic                   accept, acc_data, acc_load;
  logic [LEN_EXT_W-1:0]   len_ext, len_eff;
  logic [IdxW-1:0]        sel;
  logic                   in_range, hit, push;
  logic [MAX_PATTERN-1:0] nb, pm;
  cell_ctrl_t             ctrl;
  out_item_t              res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= 7'd1;
      icase_q  <= 1'b0;
      offset_q <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LENGTH: len_q    <= cfg_data_i[6:0];
        CFG_IGNORE_CASE:    icase_q  <= cfg_data_i[0];
        CFG_START_OFFSET:   offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid_i & in_ready_o;
  assign acc_data = accept & (in_data_i.op == OP_DATA);
  assign acc_load = accept & (in_data_i.op == OP_LOAD);

  // zero means one, above the chain length saturates
  always_comb begin
    len_ext = LEN_EXT_W'(len_q);
    len_eff = len_ext;
    if (len_ext == '0) begin
      len_eff = LEN_EXT_W'(1);
    end else if (len_ext > LEN_EXT_W'(MAX_PATTERN)) begin
      len_eff = LEN_EXT_W'(MAX_PATTERN);
    end
  end

  assign sel      = IdxW'(len_eff - LEN_EXT_W'(1));
  assign in_range = (idx_q >= offset_q);
  assign hit      = in_range & nb[sel];
  assign push     = acc_data & ~rep_q & (hit | in_data_i.last_byte);

  always_comb begin
    ctrl.load        = acc_load;
    ctrl.shift       = acc_data & ~rep_q;
    ctrl.clr         = acc_data & ~rep_q & (~in_range | hit | in_data_i.last_byte);
    ctrl.ignore_case = icase_q;
    ctrl.slot        = in_data_i.pattern_slot;
    ctrl.value       = in_data_i.value;
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cfbps_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i ((i == 0) ? 1'b1 : pm[(i == 0) ? 0 : i - 1]),
      .next_o (nb[i]),
      .match_o(pm[i])
    );
  end

  // stream position and match flag
  always_comb begin
    idx_d = idx_q;
    rep_d = rep_q;
    if (acc_data) begin
      if (in_data_i.last_byte) begin
        idx_d = 32'd0;
        rep_d = 1'b0;
      end else begin
        idx_d = idx_q + 32'd1;
        if (!rep_q && hit) begin
          rep_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 32'd0;
      rep_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      rep_q <= rep_d;
    end
  end

  always_comb begin
    res.found    = hit;
    res.position = hit ? (idx_q - (32'(len_eff) - 32'd1)) : 32'd0;
  end

  cfbps_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(res),
    .space_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // prefix bits are cleared whenever a match has been reported
  `CFBPS_ASSERT_ALWAYS(a_rep_bits_clear, clk_i, rst_ni |-> !(rep_q && (pm != '0)))
  // the last stream byte rewinds the position
  `CFBPS_ASSERT(a_last_rewinds, clk_i, rst_ni,
                (acc_data && in_data_i.last_byte) |=> (idx_q == 32'd0))
  // a not-found result only at the end of a stream
  `CFBPS_ASSERT(a_miss_at_end, clk_i, rst_ni,
                (push && !res.found) |-> in_data_i.last_byte)

endmodule

// ===== sv/cfbps_cell.sv =====
// one pattern position: stored byte, comparator and prefix match bit
`timescale 1ns / 1ps
module cfbps_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfbps_pkg::cell_ctrl_t ctrl_i,
  input  logic                  prev_i,
  output logic                  next_o,
  output logic                  match_o
);
  import cfbps_pkg::*;

  logic [7:0] pat_q;
  logic       pm_q;
  logic       pm_d;
  logic       eq;
  logic       slot_hit;

  assign slot_hit = ({3'b000, ctrl_i.slot} == LEN_EXT_W'(CellIdx));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && slot_hit) begin
      pat_q <= ctrl_i.value;
    end
  end

  assign eq = (fold_byte(pat_q, ctrl_i.ignore_case) ==
               fold_byte(ctrl_i.value, ctrl_i.ignore_case));

  // prefix through this position ends at the current byte
  assign next_o = prev_i & eq;

  always_comb begin
    pm_d = pm_q;
    if (ctrl_i.clr) begin
      pm_d = 1'b0;
    end else if (ctrl_i.shift) begin
      pm_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else begin
      pm_q <= pm_d;
    end
  end

  assign match_o = pm_q;

endmodule

// ===== sv/cfbps_out_buf.sv =====
// two-entry result queue between the match logic and the receiver
`timescale 1ns / 1ps
module cfbps_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cfbps_pkg::out_item_t push_data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfbps_pkg::out_item_t out_data_o
);
  import cfbps_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign space_o     = (cnt_q != 2'd2);
  assign pop         = out_valid_o & out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
